// ----- sv/drripdb_pkg.sv -----
// Package for the DRRIP dead-block replacement policy.
// Holds the geometry, the row layout, the register indexes and the LFSR constants.
// Depends on nothing.
package drripdb_pkg;
  localparam int SETS      = 2048;
  localparam int WAYS      = 16;
  localparam int RRPV_W    = 2;
  localparam int REUSE_W   = 2;
  localparam int SEL_W     = 10;
  localparam int SET_AW    = $clog2(SETS);
  localparam int WAY_AW    = $clog2(WAYS);
  localparam int SET_FW    = 11;
  localparam int WAY_FW    = 4;
  localparam int ROW_W     = WAYS * (RRPV_W + REUSE_W);
  localparam int DECAY_W   = 20;
  localparam int LEAD_W    = 11;
  localparam int ODDS_W    = 4;
  localparam int LFSR_W    = 16;
  localparam int CFG_IW    = 2;

  localparam logic [RRPV_W-1:0]  RRPV_TOP  = {RRPV_W{1'b1}};
  localparam logic [REUSE_W-1:0] REUSE_SAT = {REUSE_W{1'b1}};
  localparam logic [SEL_W-1:0]   SEL_MAX   = {SEL_W{1'b1}};
  localparam logic [SEL_W-1:0]   SEL_HALF  = SEL_MAX >> 1;
  localparam logic [LFSR_W-1:0]  LFSR_RESET = 16'd44257;
  localparam logic [LFSR_W-1:0]  LFSR_TAPS  = 16'hB400;

  localparam logic [CFG_IW-1:0] CFG_DECAY_INTERVAL = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LEADER_COUNT   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ODDS_SHIFT     = 2'd2;

  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // row: reuse counters above, RRPVs below, way 0 lowest in each
  localparam logic [ROW_W-1:0] ROW_RESET =
    {{(WAYS*REUSE_W){1'b0}}, {(WAYS*RRPV_W){1'b1}}};
endpackage

// ----- sv/drripdb_ram.sv -----
// Simple dual-port RAM holding one metadata row per cache set.
// One write port, one read port with registered read data. No dependencies.
module drripdb_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sv/drrip_dead_block_replacement.sv -----
// Top level of the DRRIP dead-block replacement policy.
// Uses drripdb_pkg and drripdb_ram (per-set RRPV and reuse rows).
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser command, tdata set/way/hit/evicted
//  out_    | out | out_tvalid/out_tready| tdata victim way, selector
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Each item goes through accept, row read, and modify and write back in turn.
// An update that reaches the decay interval first sweeps all 2048 rows.
// After reset a clearing pass writes every row before any item is taken.
// A stalled result holds the row write until out_tready; configuration is always taken.
module drrip_dead_block_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // set_index[10:0], way_index[14:11], was_hit[15],
                                  // victim_valid[16], zero fill
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // victim_way[3:0], selector_value[13:4], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [drripdb_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [drripdb_pkg::DECAY_W-1:0] cfg_data
);
  localparam int SETS    = drripdb_pkg::SETS;
  localparam int WAYS    = drripdb_pkg::WAYS;
  localparam int RW      = drripdb_pkg::RRPV_W;
  localparam int UW      = drripdb_pkg::REUSE_W;
  localparam int AW      = drripdb_pkg::SET_AW;
  localparam int WW      = drripdb_pkg::WAY_AW;
  localparam int ROW_W   = drripdb_pkg::ROW_W;
  localparam int RRPV_OF = 0;
  localparam int REUSE_OF = WAYS * RW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SWP  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [AW:0] cnt_r, cnt_nxt;

  logic [drripdb_pkg::DECAY_W-1:0] decay_int_r;
  logic [drripdb_pkg::LEAD_W-1:0]  lead_cnt_r;
  logic [drripdb_pkg::ODDS_W-1:0]  odds_r;
  logic [drripdb_pkg::DECAY_W-1:0] decay_cnt_r, decay_cnt_nxt;
  logic [drripdb_pkg::LFSR_W-1:0]  lfsr_r, lfsr_nxt;
  logic [drripdb_pkg::SEL_W-1:0]   psel_r, psel_nxt;

  logic                              cmd_r, hit_r, evict_r;
  logic [drripdb_pkg::SET_FW-1:0]    set_r;
  logic [WW-1:0]                     way_r;

  logic                 out_valid_r;
  logic [15:0]          out_data_r;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata;

  logic in_acc, mod_go, decay_hit;
  logic [drripdb_pkg::DECAY_W:0] decay_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign mod_go     = (state_r == S_MOD) && (!out_valid_r || out_tready);

  assign decay_inc = {1'b0, decay_cnt_r} + 21'd1;
  assign decay_hit = decay_inc >= {1'b0, decay_int_r};

  drripdb_ram #(.DEPTH(SETS), .WIDTH(ROW_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // row decode
  logic [RW-1:0] rrpv [WAYS];
  logic [UW-1:0] reuse [WAYS];
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rrpv[w]  = ram_rdata[RRPV_OF + w*RW +: RW];
      reuse[w] = ram_rdata[REUSE_OF + w*UW +: UW];
    end
  end

  // decay sweep row
  logic [ROW_W-1:0] swp_row;
  always_comb begin
    swp_row = ram_rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (reuse[w] != '0) begin
        swp_row[REUSE_OF + w*UW +: UW] = reuse[w] - UW'(1);
      end
    end
  end

  // find victim
  logic          dead_found;
  logic [WW-1:0] dead_way, top_way;
  logic [RW-1:0] top;
  logic [ROW_W-1:0] find_row;
  always_comb begin
    dead_found = 1'b0;
    dead_way   = '0;
    top_way    = '0;
    top        = '0;
    for (int w = WAYS-1; w >= 0; w--) begin
      if (rrpv[w] == drripdb_pkg::RRPV_TOP && reuse[w] == '0) begin
        dead_found = 1'b1;
        dead_way   = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rrpv[w] > top) begin
        top = rrpv[w];
      end
    end
    for (int w = WAYS-1; w >= 0; w--) begin
      if (rrpv[w] == top) begin
        top_way = WW'(w);
      end
    end
    find_row = ram_rdata;
    if (!dead_found) begin
      for (int w = 0; w < WAYS; w++) begin
        find_row[RRPV_OF + w*RW +: RW] = rrpv[w] + (drripdb_pkg::RRPV_TOP - top);
      end
    end
  end

  // update
  logic [ROW_W-1:0] upd_row;
  logic             lead_s, lead_b, srrip_pick, distant;
  logic [drripdb_pkg::LFSR_W-1:0] lfsr_step, odds_mask;
  logic [UW-1:0]    old_reuse;
  logic [AW:0]      set_sum;
  logic [AW-1:0]    set_a;
  always_comb begin
    set_a      = set_r[AW-1:0];
    set_sum    = {1'b0, set_a} + (AW+1)'(lead_cnt_r);
    lead_s     = {1'b0, set_a} < (AW+1)'(lead_cnt_r);
    lead_b     = !lead_s && (set_sum >= (AW+1)'(SETS));
    srrip_pick = lead_s || (!lead_b && psel_r >= drripdb_pkg::SEL_HALF);
    lfsr_step  = (lfsr_r >> 1) ^ (lfsr_r[0] ? drripdb_pkg::LFSR_TAPS : '0);
    odds_mask  = 16'((17'd1 << odds_r) - 17'd1);
    distant    = (lfsr_step & odds_mask) == '0;
    old_reuse  = reuse[way_r];
    upd_row    = ram_rdata;
    lfsr_nxt   = lfsr_r;
    psel_nxt   = psel_r;
    if (hit_r) begin
      upd_row[RRPV_OF + way_r*RW +: RW] = '0;
      if (old_reuse != drripdb_pkg::REUSE_SAT) begin
        upd_row[REUSE_OF + way_r*UW +: UW] = old_reuse + UW'(1);
      end
    end else begin
      upd_row[RRPV_OF + way_r*RW +: RW] = drripdb_pkg::RRPV_TOP - RW'(1);
      if (!srrip_pick) begin
        lfsr_nxt = lfsr_step;
        if (distant) begin
          upd_row[RRPV_OF + way_r*RW +: RW] = drripdb_pkg::RRPV_TOP;
        end
      end
      upd_row[REUSE_OF + way_r*UW +: UW] = '0;
      if (evict_r && (lead_s || lead_b)) begin
        if ((old_reuse != '0) == lead_s) begin
          if (psel_r != drripdb_pkg::SEL_MAX) psel_nxt = psel_r + 1'b1;
        end else begin
          if (psel_r != '0) psel_nxt = psel_r - 1'b1;
        end
      end
    end
  end

  // sequencer and memory port selection
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    decay_cnt_nxt = decay_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = drripdb_pkg::ROW_RESET;
    ram_re        = 1'b0;
    ram_raddr     = cnt_r[AW-1:0];
    unique case (state_r)
      S_CLR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == AW'(SETS-1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RD;
          cnt_nxt   = '0;
          if (in_tuser == drripdb_pkg::CMD_UPDATE) begin
            decay_cnt_nxt = decay_inc[drripdb_pkg::DECAY_W-1:0];
            if (decay_hit) begin
              decay_cnt_nxt = '0;
              state_nxt     = S_SWP;
            end
          end
        end
      end
      S_SWP: begin
        ram_re    = !cnt_r[AW];
        ram_we    = (cnt_r != '0);
        ram_waddr = AW'(cnt_r - 1'b1);
        ram_wdata = swp_row;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[AW]) begin
          state_nxt = S_RD;
          cnt_nxt   = '0;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = set_r[AW-1:0];
        state_nxt = S_MOD;
      end
      S_MOD: begin
        ram_waddr = set_r[AW-1:0];
        ram_wdata = (cmd_r == drripdb_pkg::CMD_FIND) ? find_row : upd_row;
        ram_we    = mod_go;
        if (mod_go) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      decay_int_r <= 20'd100000;
      lead_cnt_r  <= 11'd32;
      odds_r      <= 4'd5;
      decay_cnt_r <= '0;
      lfsr_r      <= drripdb_pkg::LFSR_RESET;
      psel_r      <= drripdb_pkg::SEL_HALF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      decay_cnt_r <= decay_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          drripdb_pkg::CFG_DECAY_INTERVAL: decay_int_r <= cfg_data;
          drripdb_pkg::CFG_LEADER_COUNT:   lead_cnt_r  <= cfg_data[drripdb_pkg::LEAD_W-1:0];
          drripdb_pkg::CFG_ODDS_SHIFT:     odds_r      <= cfg_data[drripdb_pkg::ODDS_W-1:0];
          default: ;
        endcase
      end
      if (mod_go && cmd_r == drripdb_pkg::CMD_UPDATE) begin
        lfsr_r <= lfsr_nxt;
        psel_r <= psel_nxt;
      end
      if (mod_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser;
      set_r   <= in_tdata[10:0];
      way_r   <= in_tdata[11 +: WW];
      hit_r   <= in_tdata[15];
      evict_r <= in_tdata[16];
    end
    if (mod_go) begin
      out_data_r <= {2'b00,
        (cmd_r == drripdb_pkg::CMD_UPDATE) ? psel_nxt : psel_r,
        (cmd_r == drripdb_pkg::CMD_FIND) ? (dead_found ? dead_way : top_way) : 4'd0};
    end
  end

  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR || state_r == S_SWP) |-> !in_tready)
    else $error("item taken during clear or sweep");
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RD || state_r == S_SWP))
    else $error("accepted word did not start a row read");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_MOD)
    else $error("result raised outside modify");
  a_sel_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MOD) |=> $stable(psel_r))
    else $error("selector moved outside modify");
endmodule

// ----- test/drrip_dead_block_replacement_tb.sv -----
// Testbench for the DRRIP dead-block replacement policy: drives find and update words,
// predicts victim way and selector from its own copy of the per-set state, checks each result.
// Depends on drripdb_pkg and drrip_dead_block_replacement.
module drrip_dead_block_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = drripdb_pkg::SETS;
  localparam int WAYS = drripdb_pkg::WAYS;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [drripdb_pkg::WAY_FW-1:0] way;
    logic [drripdb_pkg::SEL_W-1:0]  sel;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [drripdb_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [drripdb_pkg::DECAY_W-1:0] cfg_data = '0;

  drrip_dead_block_replacement dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [drripdb_pkg::RRPV_W-1:0]  rrpv_mem [SETS*WAYS];
  logic [drripdb_pkg::REUSE_W-1:0] reuse_mem [SETS*WAYS];
  logic [drripdb_pkg::SEL_W-1:0]   duel_sel;
  int unsigned                     access_count;
  logic [drripdb_pkg::LFSR_W-1:0]  ins_lfsr;
  int unsigned                     decay_every;
  int unsigned                     leader_count;
  int unsigned                     odds_shift;

  result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int finds_sent = 0;
  int sweeps_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic logic [drripdb_pkg::WAY_FW-1:0] pick_victim(int base);
    logic [drripdb_pkg::RRPV_W-1:0] top;
    for (int w = 0; w < WAYS; w++)
      if (rrpv_mem[base+w] == drripdb_pkg::RRPV_TOP && reuse_mem[base+w] == 0)
        return w[drripdb_pkg::WAY_FW-1:0];
    top = '0;
    for (int w = 0; w < WAYS; w++)
      if (rrpv_mem[base+w] > top) top = rrpv_mem[base+w];
    for (int w = 0; w < WAYS; w++)
      rrpv_mem[base+w] = rrpv_mem[base+w] + (drripdb_pkg::RRPV_TOP - top);
    for (int w = 0; w < WAYS; w++)
      if (rrpv_mem[base+w] == drripdb_pkg::RRPV_TOP) return w[drripdb_pkg::WAY_FW-1:0];
    return '0;
  endfunction

  function automatic void record_access(int set, int way, logic hit, logic evicted);
    int idx;
    int leader;
    logic srrip;
    logic lsb;
    logic [drripdb_pkg::REUSE_W-1:0] old_reuse;
    idx = set * WAYS + way;
    leader = 0;
    access_count++;
    if (access_count >= decay_every) begin
      access_count = 0;
      sweeps_seen++;
      for (int i = 0; i < SETS*WAYS; i++)
        if (reuse_mem[i] != 0) reuse_mem[i]--;
    end
    if (hit) begin
      rrpv_mem[idx] = '0;
      if (reuse_mem[idx] != drripdb_pkg::REUSE_SAT) reuse_mem[idx]++;
      return;
    end
    if (set < leader_count) leader = 1;
    else if (set + leader_count >= SETS) leader = 2;
    srrip = (leader == 1) ? 1'b1 : (leader == 2) ? 1'b0 : (duel_sel >= drripdb_pkg::SEL_HALF);
    rrpv_mem[idx] = drripdb_pkg::RRPV_TOP - 1'b1;
    if (!srrip) begin
      lsb = ins_lfsr[0];
      ins_lfsr = ins_lfsr >> 1;
      if (lsb) ins_lfsr ^= drripdb_pkg::LFSR_TAPS;
      if ((ins_lfsr & ((32'd1 << odds_shift) - 1)) == 0) rrpv_mem[idx] = drripdb_pkg::RRPV_TOP;
    end
    old_reuse = reuse_mem[idx];
    reuse_mem[idx] = '0;
    if (evicted && leader != 0) begin
      if ((leader == 1) == (old_reuse > 0)) begin
        if (duel_sel != drripdb_pkg::SEL_MAX) duel_sel++;
      end else if (duel_sel != 0) begin
        duel_sel--;
      end
    end
  endfunction

  initial begin
    for (int i = 0; i < SETS*WAYS; i++) begin
      rrpv_mem[i] = drripdb_pkg::RRPV_TOP;
      reuse_mem[i] = '0;
    end
    duel_sel = drripdb_pkg::SEL_HALF;
    access_count = 0;
    ins_lfsr = drripdb_pkg::LFSR_RESET;
    decay_every = 100000;
    leader_count = 32;
    odds_shift = 5;
  end

  task automatic send_word(logic cmd, int set, int way, logic hit, logic evicted);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'b0, evicted, hit, way[drripdb_pkg::WAY_FW-1:0], set[drripdb_pkg::SET_FW-1:0]};
    do @(posedge clk); while (!in_tready);
    r.way = '0;
    if (cmd == drripdb_pkg::CMD_FIND) begin
      r.way = pick_victim(set * WAYS);
      finds_sent++;
    end else begin
      record_access(set, way, hit, evicted);
    end
    r.sel = duel_sel;
    pending_results.push_back(r);
    words_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [drripdb_pkg::CFG_IW-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[drripdb_pkg::DECAY_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      drripdb_pkg::CFG_DECAY_INTERVAL: decay_every = value & 32'hFFFFF;
      drripdb_pkg::CFG_LEADER_COUNT:   leader_count = value & 32'h7FF;
      drripdb_pkg::CFG_ODDS_SHIFT:     odds_shift = value & 32'hF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_set();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return SETS - 1 - $urandom_range(7);
      2: return 1000 + $urandom_range(7);
      default: return $urandom_range(SETS - 1);
    endcase
  endfunction

  task automatic send_random(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      if (kind < 4)
        send_word(drripdb_pkg::CMD_FIND, pick_set(), $urandom_range(15), $urandom_range(1),
                  $urandom_range(1));
      else
        send_word(drripdb_pkg::CMD_UPDATE, pick_set(), $urandom_range(15), kind < 7,
                  $urandom_range(1));
    end
  endtask

  task automatic test_directed;
    write_reg(drripdb_pkg::CFG_DECAY_INTERVAL, 1048575);
    write_reg(drripdb_pkg::CFG_LEADER_COUNT, 32);
    write_reg(drripdb_pkg::CFG_ODDS_SHIFT, 15);
    send_word(drripdb_pkg::CMD_FIND, 0, 0, 0, 0);
    send_word(drripdb_pkg::CMD_FIND, SETS - 1, 15, 1, 1);
    send_word(drripdb_pkg::CMD_UPDATE, 0, 0, 1'b1, 1'b0);
    send_word(drripdb_pkg::CMD_UPDATE, 0, 0, 1'b0, 1'b1);
    send_word(drripdb_pkg::CMD_UPDATE, 0, 15, 1'b1, 1'b1);
    send_word(drripdb_pkg::CMD_UPDATE, 0, 15, 1'b0, 1'b1);
    send_word(drripdb_pkg::CMD_FIND, 0, 3, 1, 0);
    send_word(drripdb_pkg::CMD_UPDATE, SETS - 1, 15, 1'b1, 1'b0);
    send_word(drripdb_pkg::CMD_UPDATE, SETS - 1, 15, 1'b0, 1'b1);
    send_word(drripdb_pkg::CMD_UPDATE, SETS - 1, 7, 1'b0, 1'b1);
    send_word(drripdb_pkg::CMD_FIND, SETS - 1, 0, 0, 0);
    send_word(drripdb_pkg::CMD_UPDATE, 1024, 8, 1'b0, 1'b0);
    send_word(drripdb_pkg::CMD_FIND, 1024, 0, 0, 0);
    for (int w = 0; w < WAYS; w++) send_word(drripdb_pkg::CMD_UPDATE, 5, w, 1'b1, 1'b0);
    send_word(drripdb_pkg::CMD_FIND, 5, 0, 0, 0);
    drain();
  endtask

  task automatic test_config_extremes;
    write_reg(drripdb_pkg::CFG_DECAY_INTERVAL, 1);
    write_reg(drripdb_pkg::CFG_ODDS_SHIFT, 0);
    write_reg(drripdb_pkg::CFG_LEADER_COUNT, 0);
    send_word(drripdb_pkg::CMD_UPDATE, 5, 2, 1'b1, 1'b0);
    send_word(drripdb_pkg::CMD_UPDATE, 1500, 4, 1'b0, 1'b1);
    send_word(drripdb_pkg::CMD_FIND, 5, 0, 0, 0);
    drain();
    write_reg(drripdb_pkg::CFG_DECAY_INTERVAL, 0);
    write_reg(drripdb_pkg::CFG_LEADER_COUNT, 1500);
    send_word(drripdb_pkg::CMD_UPDATE, 1200, 1, 1'b0, 1'b1);
    send_word(drripdb_pkg::CMD_UPDATE, SETS - 1, 1, 1'b0, 1'b1);
    drain();
    write_reg(drripdb_pkg::CFG_LEADER_COUNT, 1024);
    write_reg(drripdb_pkg::CFG_DECAY_INTERVAL, 20);
    send_random(60);
    drain();
  endtask

  task automatic test_random_phases;
    write_reg(drripdb_pkg::CFG_DECAY_INTERVAL, 250);
    write_reg(drripdb_pkg::CFG_LEADER_COUNT, 4);
    write_reg(drripdb_pkg::CFG_ODDS_SHIFT, 1);
    send_idle = 28;
    recv_idle = 80;
    send_random(600);
    drain();
    write_reg(drripdb_pkg::CFG_ODDS_SHIFT, 3);
    write_reg(drripdb_pkg::CFG_LEADER_COUNT, 2047);
    send_idle = 80;
    recv_idle = 28;
    send_random(600);
    drain();
    write_reg(drripdb_pkg::CFG_ODDS_SHIFT, 2);
    write_reg(drripdb_pkg::CFG_LEADER_COUNT, 6);
    write_reg(drripdb_pkg::CFG_DECAY_INTERVAL, 400);
    send_idle = 0;
    recv_idle = 0;
    send_random(600);
    drain();
  endtask

  task automatic test_backpressure;
    send_idle = 0;
    recv_idle = 0;
    hold_left = 300;
    send_random(40);
    drain();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    $display("Covered %0d words (%0d finds), %0d results, %0d decay sweeps, selector at %0d.",
             words_sent, finds_sent, results_seen, sweeps_seen, duel_sel);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[3:0] !== want.way) begin
          errors++;
          $display("%0t: victim_way expected %0d actual %0d", $time, want.way, out_tdata[3:0]);
        end
        if (out_tdata[13:4] !== want.sel) begin
          errors++;
          $display("%0t: selector expected %0d actual %0d", $time, want.sel, out_tdata[13:4]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Timeout after %0d cycles without progress", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule

// ----- sim.f -----
sv/drripdb_pkg.sv
sv/drripdb_ram.sv
sv/drrip_dead_block_replacement.sv
test/drrip_dead_block_replacement_tb.sv
